>>> design/bgu_pkg.sv
// ----------------------------------------------------------------------------
// bgu_pkg
// Shared types, constants and digit weights for the base-255 group unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgu_pkg;

  localparam int unsigned GroupDigits = 5;
  localparam int unsigned PosWidth    = 3;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned WordBytes   = WordWidth / ByteWidth;
  localparam int unsigned CntWidth    = $clog2(WordBytes);

  localparam logic [ByteWidth-1:0] TailXor = 8'hBE;
  localparam logic [PosWidth-1:0]  LastPos = PosWidth'(GroupDigits - 1);

  typedef enum logic {
    REQ_GROUP = 1'b0,
    REQ_TAIL  = 1'b1
  } req_type_e;

  // One pending output word for the serializer
  typedef struct packed {
    logic [WordWidth-1:0] word;  // bytes go out from the top byte down
    logic [CntWidth-1:0]  cnt;   // bytes left after the first one
  } bgu_load_t;

  // Weight 255^pos of a digit, modulo 2^32
  function automatic logic [WordWidth-1:0] digit_weight(input logic [PosWidth-1:0] pos);
    logic [WordWidth-1:0] w;
    case (pos)
      3'd0:    w = 32'd1;
      3'd1:    w = 32'd255;
      3'd2:    w = 32'd65025;
      3'd3:    w = 32'd16581375;
      default: w = 32'd4228250625;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/bgu_digit_acc.sv
// ----------------------------------------------------------------------------
// bgu_digit_acc
// Running base-255 sum over the digits of one group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgu_digit_acc (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [bgu_pkg::ByteWidth-1:0] digit_i,
  output logic [bgu_pkg::WordWidth-1:0]  sum_o,
  output logic                           last_digit_o
);
  import bgu_pkg::*;

  logic [PosWidth-1:0]        pos_q, pos_d, pos_idx;
  logic [WordWidth-1:0]       sum_q, sum_d;
  logic [WordWidth-1:0]       prod;

  // positions past the last digit count as the last digit
  assign pos_idx      = (pos_q >= LastPos) ? LastPos : pos_q;
  assign last_digit_o = (pos_idx == LastPos);

  // only the low word of the product matters for a sum modulo 2^32
  assign prod  = WordWidth'(digit_i) * digit_weight(pos_idx);
  assign sum_o = sum_q + prod;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (step_i) begin
      if (last_digit_o) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_idx + PosWidth'(1);
        sum_d = sum_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

>>> design/bgu_out_ser.sv
// ----------------------------------------------------------------------------
// bgu_out_ser
// Holds one output word and sends its bytes out one per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgu_out_ser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire bgu_pkg::bgu_load_t            load_data_i,
  output logic                               free_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [bgu_pkg::ByteWidth-1:0]      data_o,
  output logic                               last_o
);
  import bgu_pkg::*;

  logic                 valid_q, valid_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [WordWidth-1:0] word_q, word_d;
  logic                 fire;

  assign fire    = valid_q && ready_i;
  // free when empty or when the final byte leaves this cycle
  assign free_o  = !valid_q || (fire && (cnt_q == '0));
  assign valid_o = valid_q;
  assign data_o  = word_q[WordWidth-1 -: ByteWidth];
  assign last_o  = (cnt_q == '0);

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = load_data_i.cnt;
      word_d  = load_data_i.word;
    end else if (fire) begin
      if (cnt_q == '0) begin
        valid_d = 1'b0;
      end else begin
        cnt_d  = cnt_q - CntWidth'(1);
        word_d = word_q << ByteWidth;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

`default_nettype wire

>>> design/base255_group_unpacker.sv
// ----------------------------------------------------------------------------
// base255_group_unpacker
// Turns groups of five base-255 digits into four binary bytes.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless a word in the input register waits for
// the output word register. A group word (tuser = 0) is a little-endian
// base-255 digit; on the fifth digit the 32-bit sum modulo 2^32 is sent as
// four words, most significant byte first, with tlast on the fourth. A tail
// word (tuser = 1) goes out XORed with 0xBE and with tlast set; it leaves an
// open group untouched. An accepted word sits in an input register until it
// can advance, then updates the digit accumulator and, if it makes output,
// loads the output word register, which drives its first output word. The
// output side sends one word per cycle while m_axis_tready is high, so a
// finished group holds the output register for its four words and a tail
// word for one; the input takes a word each cycle as long as that rate keeps up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base255_group_unpacker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tuser,   // [0] req_type
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // run_last
);
  import bgu_pkg::*;

  logic                 s1_valid_q;
  req_type_e            s1_type_q;
  logic [ByteWidth-1:0] s1_byte_q;

  logic                 in_fire;
  logic                 s1_adv;
  logic                 needs_out;
  logic                 acc_step;
  logic                 last_digit;
  logic [WordWidth-1:0] sum_next;
  logic                 ser_free;
  logic                 ser_load;
  bgu_load_t            ser_load_data;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign needs_out     = (s1_type_q == REQ_TAIL) || last_digit;
  // advance when no output is made or the output register takes it
  assign s1_adv        = s1_valid_q && (!needs_out || ser_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign acc_step = s1_adv && (s1_type_q == REQ_GROUP);
  assign ser_load = s1_adv && needs_out;

  always_comb begin
    if (s1_type_q == REQ_TAIL) begin
      ser_load_data.word = {s1_byte_q ^ TailXor, (WordWidth-ByteWidth)'(0)};
      ser_load_data.cnt  = '0;
    end else begin
      ser_load_data.word = sum_next;
      ser_load_data.cnt  = CntWidth'(WordBytes - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q <= req_type_e'(s_axis_tuser);
      s1_byte_q <= s_axis_tdata;
    end
  end

  bgu_digit_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (acc_step),
    .digit_i      (s1_byte_q),
    .sum_o        (sum_next),
    .last_digit_o (last_digit)
  );

  bgu_out_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ser_load),
    .load_data_i (ser_load_data),
    .free_o      (ser_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> design/bgu_checker.sv
// ----------------------------------------------------------------------------
// bgu_checker
// Port-level checks on the base-255 group unpacker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // input only backs up behind a pending output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output idle");

  // a group keeps going until its last byte
  a_group_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("group output broken before last byte");

  // a fresh output run comes from an input word that passed the input register and loaded the output word register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output appeared without an input word");

endmodule

bind base255_group_unpacker bgu_checker u_bgu_checker (.*);

`default_nettype wire
